[src/vblf_pkg.sv]
// ----------------------------------------------------------------------------
// Baseline line fit package
// Shared widths, payload structs, codes and control types for the baseline
// line fit block.
// ----------------------------------------------------------------------------
`default_nettype none

package vblf_pkg;

    localparam int V_W         = 16;
    localparam int C_W         = 24;
    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W        = V_W + CNT_W - 1;
    localparam int SY_W        = C_W + CNT_W - 1;
    localparam int SXY_W       = V_W + C_W + CNT_W - 1;
    localparam int SXX_W       = 2 * V_W + CNT_W - 1;
    localparam int MOP_W       = SXY_W;
    localparam int PROD_W      = 2 * MOP_W;
    localparam int DEN_W       = CNT_W + SXX_W + 3;
    localparam int MUL_CNT_W   = $clog2(MOP_W + 1);
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int SLOPE_W     = 48;
    localparam int ICPT_W      = 40;
    localparam int SLOPE_FRAC  = 16;
    localparam int ICPT_FRAC   = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOUNDS_EQUAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_START     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DEGENERATE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DIR   = 2'd2;

    typedef struct packed {
        logic signed [V_W-1:0] voltage_sample;
        logic signed [C_W-1:0] current_sample;
        logic                  last_sample;
    } sample_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       fit_status;
        logic signed [SLOPE_W-1:0] line_slope;
        logic signed [ICPT_W-1:0]  line_intercept;
        logic [CNT_W-1:0]          points_used;
    } result_t;

    typedef enum logic [2:0] {
        MO_D_ADD,
        MO_D_SUB,
        MO_NS_ADD,
        MO_NS_SUB,
        MO_NI_ADD,
        MO_NI_SUB
    } mul_op_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_TAKE,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_TAKE_H,
        S_ADD_H,
        S_TAKE_I,
        S_ADD_I,
        S_MUL,
        S_MUL_WAIT,
        S_CHECK,
        S_DIV,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                latch_in;
        logic                hold;
        logic                set_step;
        logic                op_held;
        logic                prod_load;
        logic                sum_add;
        logic                clear;
        logic                mul_start;
        mul_op_t             mul_op;
        logic                div_start;
        logic                div_icpt;
        logic                load_out;
        logic [STATUS_W-1:0] out_code;
    } cmd_t;

    typedef struct packed {
        logic beq;
        logic moves;
        logic start_ok;
        logic end_hit;
        logic cap_hit;
        logic last;
        logic count_zero;
        logic d_pos;
        logic mul_done;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [V_W:0] vdist(input logic signed [V_W-1:0] a,
                                           input logic signed [V_W-1:0] b);
        logic signed [V_W:0] d;
        d = $signed({a[V_W-1], a}) - $signed({b[V_W-1], b});
        return d[V_W] ? (V_W+1)'(-d) : (V_W+1)'(d);
    endfunction

endpackage

`default_nettype wire

[src/vblf_mul.sv]
// ----------------------------------------------------------------------------
// Baseline line fit multiplier
// Signed shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vblf_mul
    import vblf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [MOP_W-1:0]  a,
    input  wire logic signed [MOP_W-1:0]  b,
    output logic                          done,
    output logic signed [PROD_W-1:0]      prod
);

    logic                  busy_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [MUL_CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0]     acc_reg;
    logic [PROD_W-1:0]     ash_reg;
    logic [MOP_W-1:0]      bsh_reg;
    logic                  neg_reg;
    logic [MOP_W-1:0]      a_mag;
    logic [MOP_W-1:0]      b_mag;

    assign a_mag = a[MOP_W-1] ? MOP_W'(-a) : MOP_W'(a);
    assign b_mag = b[MOP_W-1] ? MOP_W'(-b) : MOP_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MOP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= PROD_W'(a_mag);
            bsh_reg <= b_mag;
            neg_reg <= a[MOP_W-1] ^ b[MOP_W-1];
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= ash_reg << 1;
            bsh_reg <= bsh_reg >> 1;
        end
        else if (fin_reg && neg_reg)
        begin
            acc_reg <= -acc_reg;
        end
    end

    assign done = done_reg;
    assign prod = $signed(acc_reg);

endmodule

`default_nettype wire

[src/vblf_div.sv]
// ----------------------------------------------------------------------------
// Baseline line fit divider
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vblf_div
    import vblf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [PROD_W-1:0] num,
    input  wire logic [DEN_W-1:0]         den,
    output logic                          done,
    output logic [PROD_W-1:0]             quo,
    output logic                          neg
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0]     nsh_reg;
    logic [PROD_W-1:0]     q_reg;
    logic [DEN_W-1:0]      r_reg;
    logic                  neg_reg;
    logic [DEN_W:0]        r2;
    logic [DEN_W:0]        r2_sub;
    logic                  ge;

    assign r2     = {r_reg, nsh_reg[PROD_W-1]};
    assign r2_sub = r2 - {1'b0, den};
    assign ge     = r2 >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nsh_reg <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
            q_reg   <= '0;
            r_reg   <= '0;
            neg_reg <= num[PROD_W-1];
        end
        else if (busy_reg)
        begin
            nsh_reg <= nsh_reg << 1;
            q_reg   <= {q_reg[PROD_W-2:0], ge};
            r_reg   <= ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign neg  = neg_reg;

endmodule

`default_nettype wire

[src/vblf_dp.sv]
// ----------------------------------------------------------------------------
// Baseline line fit datapath
// Configuration, sample and window registers, running sums, the fit
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vblf_dp
    import vblf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 sample_valid,
    input  wire sample_t              sample_data,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    output logic                      fit_valid,
    input  wire logic                 fit_ready,
    output result_t                   fit_data
);

    localparam logic [PROD_W-1:0] SLOPE_LIM = PROD_W'(1) << (SLOPE_W - 1);
    localparam logic [PROD_W-1:0] ICPT_LIM  = PROD_W'(1) << (ICPT_W - 1);

    logic signed [V_W-1:0]         bstart_reg;
    logic signed [V_W-1:0]         bend_reg;
    logic                          dir_reg;
    sample_t                       in_reg;
    logic signed [V_W-1:0]         held_v_reg;
    logic signed [C_W-1:0]         held_c_reg;
    logic [V_W-1:0]                step_reg;
    logic                          step_known_reg;
    logic signed [SX_W-1:0]        sx_reg;
    logic signed [SY_W-1:0]        sy_reg;
    logic signed [SXY_W-1:0]       sxy_reg;
    logic signed [SXX_W-1:0]       sxx_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [V_W+C_W-1:0]     pxy_reg;
    logic signed [2*V_W-1:0]       pxx_reg;
    logic signed [PROD_W-1:0]      d_reg;
    logic signed [PROD_W-1:0]      ns_reg;
    logic signed [PROD_W-1:0]      ni_reg;
    logic signed [SLOPE_W-1:0]     slope_reg;
    logic signed [ICPT_W-1:0]      icpt_reg;
    logic                          fit_valid_reg;
    result_t                       fit_reg;

    logic                          swap;
    logic signed [V_W-1:0]         bnd_s;
    logic signed [V_W-1:0]         bnd_e;
    logic [V_W-1:0]                new_step;
    logic [V_W-1:0]                step_eff;
    logic signed [V_W-1:0]         op_v;
    logic signed [C_W-1:0]         op_c;
    logic signed [MOP_W-1:0]       mul_a;
    logic signed [MOP_W-1:0]       mul_b;
    logic signed [MOP_W-1:0]       n_ext;
    logic                          mul_done;
    logic signed [PROD_W-1:0]      mul_prod;
    logic signed [PROD_W-1:0]      div_num;
    logic                          div_done;
    logic [PROD_W-1:0]             div_quo;
    logic                          div_neg;
    logic [PROD_W-1:0]             slope_lim;
    logic [PROD_W-1:0]             icpt_lim;
    logic [PROD_W-1:0]             slope_q;
    logic [PROD_W-1:0]             icpt_q;
    logic                          out_free;

    assign swap  = dir_reg ? (bstart_reg > bend_reg) : (bend_reg > bstart_reg);
    assign bnd_s = swap ? bend_reg : bstart_reg;
    assign bnd_e = swap ? bstart_reg : bend_reg;

    assign new_step = V_W'(vdist(held_v_reg, in_reg.voltage_sample));
    assign step_eff = step_known_reg ? step_reg : new_step;
    assign op_v     = cmd.op_held ? held_v_reg : in_reg.voltage_sample;
    assign op_c     = cmd.op_held ? held_c_reg : in_reg.current_sample;
    assign n_ext    = MOP_W'($signed({1'b0, cnt_reg}));
    assign out_free = !fit_valid_reg || fit_ready;

    always_comb
    begin
        stat.beq        = (bnd_s == bnd_e);
        stat.moves      = dir_reg ? (in_reg.voltage_sample > held_v_reg)
                                  : (in_reg.voltage_sample < held_v_reg);
        stat.start_ok   = vdist(bnd_s, held_v_reg) <= {1'b0, step_eff};
        stat.end_hit    = vdist(bnd_e, op_v) <= {1'b0, step_reg};
        stat.cap_hit    = cnt_reg >= CNT_W'(MAX_SAMPLES);
        stat.last       = in_reg.last_sample;
        stat.count_zero = (cnt_reg == '0);
        stat.d_pos      = !d_reg[PROD_W-1] && (d_reg != '0);
        stat.mul_done   = mul_done;
        stat.div_done   = div_done;
        stat.out_free   = out_free;
    end

    always_comb
    begin
        unique case (cmd.mul_op)
            MO_D_ADD:
            begin
                mul_a = MOP_W'(sxx_reg);
                mul_b = n_ext;
            end
            MO_D_SUB:
            begin
                mul_a = MOP_W'(sx_reg);
                mul_b = MOP_W'(sx_reg);
            end
            MO_NS_ADD:
            begin
                mul_a = MOP_W'(sxy_reg);
                mul_b = n_ext;
            end
            MO_NS_SUB:
            begin
                mul_a = MOP_W'(sx_reg);
                mul_b = MOP_W'(sy_reg);
            end
            MO_NI_ADD:
            begin
                mul_a = MOP_W'(sxx_reg);
                mul_b = MOP_W'(sy_reg);
            end
            MO_NI_SUB:
            begin
                mul_a = MOP_W'(sxy_reg);
                mul_b = MOP_W'(sx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vblf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign div_num = cmd.div_icpt ? (ni_reg <<< ICPT_FRAC) : (ns_reg <<< SLOPE_FRAC);

    vblf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (d_reg[DEN_W-1:0]),
        .done  (div_done),
        .quo   (div_quo),
        .neg   (div_neg)
    );

    assign slope_lim = div_neg ? SLOPE_LIM : SLOPE_LIM - 1'b1;
    assign icpt_lim  = div_neg ? ICPT_LIM : ICPT_LIM - 1'b1;
    assign slope_q   = (div_quo > slope_lim) ? slope_lim : div_quo;
    assign icpt_q    = (div_quo > icpt_lim) ? icpt_lim : div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstart_reg     <= '0;
            bend_reg       <= '0;
            dir_reg        <= 1'b0;
            held_v_reg     <= '0;
            held_c_reg     <= '0;
            step_reg       <= '0;
            step_known_reg <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxy_reg        <= '0;
            sxx_reg        <= '0;
            cnt_reg        <= '0;
            fit_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BOUND_START: bstart_reg <= $signed(cfg_data[V_W-1:0]);
                    CFG_BOUND_END:   bend_reg   <= $signed(cfg_data[V_W-1:0]);
                    CFG_SWEEP_DIR:   dir_reg    <= cfg_data[0];
                    default:         ;
                endcase
            end

            if (cmd.clear)
            begin
                held_v_reg     <= '0;
                held_c_reg     <= '0;
                step_reg       <= '0;
                step_known_reg <= 1'b0;
                sx_reg         <= '0;
                sy_reg         <= '0;
                sxy_reg        <= '0;
                sxx_reg        <= '0;
                cnt_reg        <= '0;
            end
            else
            begin
                if (cmd.hold)
                begin
                    held_v_reg <= in_reg.voltage_sample;
                    held_c_reg <= in_reg.current_sample;
                end
                if (cmd.set_step && !step_known_reg)
                begin
                    step_reg       <= new_step;
                    step_known_reg <= 1'b1;
                end
                if (cmd.sum_add)
                begin
                    sx_reg  <= sx_reg + SX_W'(op_v);
                    sy_reg  <= sy_reg + SY_W'(op_c);
                    sxy_reg <= sxy_reg + SXY_W'(pxy_reg);
                    sxx_reg <= sxx_reg + SXX_W'(pxx_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            if (cmd.load_out)
            begin
                fit_valid_reg <= 1'b1;
            end
            else if (fit_ready)
            begin
                fit_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in && sample_valid)
        begin
            in_reg <= sample_data;
        end
        if (cmd.prod_load)
        begin
            pxy_reg <= op_v * op_c;
            pxx_reg <= op_v * op_v;
        end
        if (mul_done)
        begin
            unique case (cmd.mul_op)
                MO_D_ADD:  d_reg  <= mul_prod;
                MO_D_SUB:  d_reg  <= d_reg - mul_prod;
                MO_NS_ADD: ns_reg <= mul_prod;
                MO_NS_SUB: ns_reg <= ns_reg - mul_prod;
                MO_NI_ADD: ni_reg <= mul_prod;
                MO_NI_SUB: ni_reg <= ni_reg - mul_prod;
                default:   ;
            endcase
        end
        if (div_done)
        begin
            if (cmd.div_icpt)
            begin
                icpt_reg <= div_neg ? -$signed(icpt_q[ICPT_W-1:0])
                                    : $signed(icpt_q[ICPT_W-1:0]);
            end
            else
            begin
                slope_reg <= div_neg ? -$signed(slope_q[SLOPE_W-1:0])
                                     : $signed(slope_q[SLOPE_W-1:0]);
            end
        end
        if (cmd.load_out)
        begin
            fit_reg.fit_status     <= cmd.out_code;
            fit_reg.line_slope     <= (cmd.out_code == STATUS_OK) ? slope_reg : '0;
            fit_reg.line_intercept <= (cmd.out_code == STATUS_OK) ? icpt_reg : '0;
            fit_reg.points_used    <= cnt_reg;
        end
    end

    assign fit_valid = fit_valid_reg;
    assign fit_data  = fit_reg;

endmodule

`default_nettype wire

[src/vblf_ctrl.sv]
// ----------------------------------------------------------------------------
// Baseline line fit controller
// Scan phase tracking and sequencing of sample handling and the fit.
// ----------------------------------------------------------------------------
`default_nettype none

module vblf_ctrl
    import vblf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  sample_valid,
    output logic       sample_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t              state_reg;
    state_t              state_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic                first_reg;
    logic                first_next;
    logic [STATUS_W-1:0] code_reg;
    logic [STATUS_W-1:0] code_next;
    logic [2:0]          k_reg;
    logic [2:0]          k_next;
    logic                icpt_reg;
    logic                icpt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_SEARCH;
            first_reg <= 1'b0;
            code_reg  <= STATUS_OK;
            k_reg     <= '0;
            icpt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            first_reg <= first_next;
            code_reg  <= code_next;
            k_reg     <= k_next;
            icpt_reg  <= icpt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        code_next    = code_reg;
        k_next       = k_reg;
        icpt_next    = icpt_reg;
        cmd          = '0;
        cmd.mul_op   = mul_op_t'(k_reg);
        cmd.div_icpt = icpt_reg;
        cmd.out_code = code_reg;
        cmd.op_held  = (state_reg == S_TAKE_H) || (state_reg == S_ADD_H);
        sample_ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = 1'b1;
                if (sample_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (first_reg)
                        begin
                            cmd.set_step = 1'b1;
                        end
                        if (first_reg && !stat.beq && stat.moves && stat.start_ok)
                        begin
                            phase_next = PH_TAKE;
                            state_next = S_TAKE_H;
                        end
                        else
                        begin
                            cmd.hold   = 1'b1;
                            first_next = 1'b1;
                            if (stat.last)
                            begin
                                code_next  = stat.beq ? STATUS_BOUNDS_EQUAL : STATUS_NO_START;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    end
                    PH_TAKE:
                    begin
                        state_next = S_TAKE_I;
                    end
                    default:
                    begin
                        if (stat.last)
                        begin
                            cmd.clear  = 1'b1;
                            phase_next = PH_SEARCH;
                            first_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TAKE_H, S_TAKE_I:
            begin
                if (stat.end_hit || ((state_reg == S_TAKE_I)
                                     && (stat.last || stat.cap_hit)))
                begin
                    phase_next = PH_DONE;
                    k_next     = '0;
                    if (stat.count_zero)
                    begin
                        code_next  = STATUS_DEGENERATE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        code_next  = STATUS_OK;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    cmd.prod_load = 1'b1;
                    state_next    = (state_reg == S_TAKE_H) ? S_ADD_H : S_ADD_I;
                end
            end
            S_ADD_H:
            begin
                cmd.sum_add = 1'b1;
                state_next  = S_TAKE_I;
            end
            S_ADD_I:
            begin
                cmd.sum_add = 1'b1;
                state_next  = S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    if (mul_op_t'(k_reg) == MO_NI_SUB)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_CHECK:
            begin
                icpt_next = 1'b0;
                if (stat.d_pos)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    code_next  = STATUS_DEGENERATE;
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (icpt_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        icpt_next  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.last)
                    begin
                        cmd.clear  = 1'b1;
                        phase_next = PH_SEARCH;
                        first_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/voltammogram_baseline_line_fit.sv]
// ----------------------------------------------------------------------------
// Voltammogram baseline line fit
// Fits a least-squares baseline line over a voltage window of one scan.
// ----------------------------------------------------------------------------
// Samples of a scan arrive as beats on the sample channel, the final one
// flagged by last_sample. One result beat leaves on the fit channel for each
// scan, carrying status, slope, intercept and the number of points used.
// An ordinary sample passes through the controller steps and, inside the window,
// a multiply then an add of the running sums.
// The beat that closes the window starts the fit: six products on a shared
// one-bit-per-cycle multiplier and two divisions on a one-bit-per-cycle
// divider.
// The window bounds and sweep direction are written through the cfg port,
// one register per cycle; the user must write them only while no scan is
// in progress, as the block itself does not enforce it.
// Reset clears the scan state, the configuration and the running sums; no result is pending.
// The result is held in an output register; a stalled receiver only blocks
// the block once a further result is ready to be written.
// ----------------------------------------------------------------------------
`default_nettype none

module voltammogram_baseline_line_fit
    import vblf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire sample_t              sample_data,
    output logic                      fit_valid,
    input  wire logic                 fit_ready,
    output result_t                   fit_data
);

    cmd_t  cmd;
    stat_t stat;

    vblf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    vblf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_data  (sample_data),
        .cmd          (cmd),
        .stat         (stat),
        .fit_valid    (fit_valid),
        .fit_ready    (fit_ready),
        .fit_data     (fit_data)
    );

endmodule

`default_nettype wire

[src/vblf_checker.sv]
// ----------------------------------------------------------------------------
// Baseline line fit checker
// Port-level properties of the baseline line fit block.
// ----------------------------------------------------------------------------
`default_nettype none

module vblf_checker
    import vblf_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_ready,
    input wire logic    fit_valid,
    input wire logic    fit_ready,
    input wire result_t fit_data
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && !fit_ready |=> fit_valid && $stable(fit_data))
        else $error("Result beat changed before it was taken.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("Sample taken while the previous one was still in work.");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && (fit_data.fit_status != STATUS_OK)
        |-> (fit_data.line_slope == '0) && (fit_data.line_intercept == '0))
        else $error("Failed fit carries a non-zero line.");

    a_no_points: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid && ((fit_data.fit_status == STATUS_BOUNDS_EQUAL)
                      || (fit_data.fit_status == STATUS_NO_START))
        |-> (fit_data.points_used == '0))
        else $error("Window not searched but points reported.");

    a_point_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fit_valid |-> (fit_data.points_used <= CNT_W'(MAX_SAMPLES)))
        else $error("Point count beyond the sample cap.");

endmodule

bind voltammogram_baseline_line_fit vblf_checker u_vblf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .fit_valid    (fit_valid),
    .fit_ready    (fit_ready),
    .fit_data     (fit_data)
);

`default_nettype wire
